### rtl/core/ixalu_pkg.sv
// ----------------------------------------------------------------------------
// ixalu_pkg: shared types and codes of the x86 integer ALU
// Operation codes, sequencer states and the divider control/status bundles.
// ----------------------------------------------------------------------------
package ixalu_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned SIZE_W = 2;

  // operation codes
  localparam logic [KIND_W-1:0] K_ADD  = 5'd0;
  localparam logic [KIND_W-1:0] K_ADC  = 5'd1;
  localparam logic [KIND_W-1:0] K_SUB  = 5'd2;
  localparam logic [KIND_W-1:0] K_SBB  = 5'd3;
  localparam logic [KIND_W-1:0] K_MUL  = 5'd4;
  localparam logic [KIND_W-1:0] K_IMUL = 5'd5;
  localparam logic [KIND_W-1:0] K_DIV  = 5'd6;
  localparam logic [KIND_W-1:0] K_IDIV = 5'd7;
  localparam logic [KIND_W-1:0] K_MOD  = 5'd8;
  localparam logic [KIND_W-1:0] K_IMOD = 5'd9;
  localparam logic [KIND_W-1:0] K_AND  = 5'd10;
  localparam logic [KIND_W-1:0] K_XOR  = 5'd11;
  localparam logic [KIND_W-1:0] K_OR   = 5'd12;
  localparam logic [KIND_W-1:0] K_SHL  = 5'd13;
  localparam logic [KIND_W-1:0] K_SHR  = 5'd14;
  localparam logic [KIND_W-1:0] K_SAR  = 5'd15;
  localparam logic [KIND_W-1:0] K_SAL  = 5'd16;

  // operand size codes
  localparam logic [SIZE_W-1:0] SZ_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_16 = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic sgn;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/core/x86_integer_alu_flags.sv
// Sequence: add, sub, logic ops and shifts go from accept to ST_FIN, multiplies
// pass through ST_MUL and divide and modulo through ST_DIV (a zero divisor goes
// straight to ST_FIN); ST_FIN loads the output register once the output is free.
// Throughput: one transaction at a time; divide and modulo wait on the radix-2 loop.
// Reset: rst clears the five flags, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// x86_integer_alu_flags: x86-style integer ALU with CF, PF, ZF, SF and OF
// Combinational add/logic/shift, one registered multiplier, iterative divider.
// ----------------------------------------------------------------------------
module x86_integer_alu_flags (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ixalu_pkg::KIND_W-1:0]  kind,
  input  logic [ixalu_pkg::WORD_W-1:0]  source_operand,
  input  logic [ixalu_pkg::WORD_W-1:0]  dest_operand,
  input  logic [ixalu_pkg::SIZE_W-1:0]  operand_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ixalu_pkg::WORD_W-1:0]  value,
  output logic                          carry_out,
  output logic                          parity_out,
  output logic                          zero_out,
  output logic                          sign_out,
  output logic                          overflow_out,
  output logic                          divide_error
);

  localparam int unsigned W = ixalu_pkg::WORD_W;
  localparam int unsigned H = ixalu_pkg::HALF_W;

  ixalu_pkg::state_t state, state_next;

  logic [ixalu_pkg::KIND_W-1:0] kind_q;
  logic [W-1:0]                 src_q;
  logic [W-1:0]                 dst_q;
  logic [ixalu_pkg::SIZE_W-1:0] size_q;
  logic [W-1:0]                 prod;
  logic cf, pf, zf, sf, of;

  ixalu_pkg::div_ctrl_t div_ctrl;
  ixalu_pkg::div_sts_t  div_sts;
  logic [H-1:0]         div_q;
  logic [H-1:0]         div_r;

  logic accept;
  logic fin_go;
  logic is_div_in;

  assign in_ready  = (state == ixalu_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_div_in = (kind == ixalu_pkg::K_DIV) || (kind == ixalu_pkg::K_IDIV) ||
                     (kind == ixalu_pkg::K_MOD) || (kind == ixalu_pkg::K_IMOD);
  assign fin_go    = (state == ixalu_pkg::ST_FIN) && (!out_valid || out_ready);

  // start the divider straight from an accepted divide or modulo with a nonzero divisor
  assign div_ctrl.start = accept && is_div_in && (source_operand != '0);
  assign div_ctrl.sgn   = (kind == ixalu_pkg::K_IDIV) || (kind == ixalu_pkg::K_IMOD);

  ixalu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (dest_operand),
    .divisor   (source_operand),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= ixalu_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ixalu_pkg::ST_IDLE: begin
        if (accept) begin
          if (div_ctrl.start) state_next = ixalu_pkg::ST_DIV;
          else if (kind == ixalu_pkg::K_MUL || kind == ixalu_pkg::K_IMUL)
            state_next = ixalu_pkg::ST_MUL;
          else state_next = ixalu_pkg::ST_FIN;
        end
      end
      ixalu_pkg::ST_MUL: state_next = ixalu_pkg::ST_FIN;
      ixalu_pkg::ST_DIV: if (div_sts.done) state_next = ixalu_pkg::ST_FIN;
      ixalu_pkg::ST_FIN: if (fin_go) state_next = ixalu_pkg::ST_IDLE;
      default: state_next = ixalu_pkg::ST_IDLE;
    endcase
  end

  // capture operands
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      src_q  <= source_operand;
      dst_q  <= dest_operand;
      size_q <= operand_size;
    end
  end

  // shared operand decode
  logic [H-1:0] s, d, m;
  logic         is_imul;
  logic [H:0]   ma, mb;
  logic [2*H+1:0] pfull;

  assign s = src_q[H-1:0];
  assign d = dst_q[H-1:0];
  always_comb begin
    case (size_q)
      ixalu_pkg::SZ_8:  m = 32'h0000_00ff;
      ixalu_pkg::SZ_16: m = 32'h0000_ffff;
      default:          m = 32'hffff_ffff;
    endcase
  end

  // multiply stage: signed 33x33 covers both mul and imul
  assign is_imul = (kind_q == ixalu_pkg::K_IMUL);
  assign ma      = is_imul ? {s[H-1], s} : {1'b0, s & m};
  assign mb      = is_imul ? {d[H-1], d} : {1'b0, d & m};
  assign pfull   = $signed(ma) * $signed(mb);

  always_ff @(posedge clk) begin
    if (state == ixalu_pkg::ST_MUL) prod <= pfull[W-1:0];
  end

  // result and flag evaluation
  logic [H:0]   sum33, dif33;
  logic [4:0]   cnt, cm1;
  logic [W-1:0] x64, se64, shl64, shr64, sar64;
  logic [H-1:0] sres;
  logic         scf;
  logic [W-1:0] psx;
  logic [W-1:0] val_n;
  logic cf_n, pf_n, zf_n, sf_n, of_n, derr_n;

  assign sum33 = {1'b0, s} + {1'b0, d} + {{H{1'b0}}, (kind_q == ixalu_pkg::K_ADC) & cf};
  assign dif33 = {1'b0, d} - {1'b0, s} - {{H{1'b0}}, (kind_q == ixalu_pkg::K_SBB) & cf};
  assign cnt   = s[4:0];
  assign cm1   = cnt - 5'd1;
  assign x64   = {{H{1'b0}}, d & m};
  always_comb begin
    case (size_q)
      ixalu_pkg::SZ_8:  se64 = {{(W-8){d[7]}}, d[7:0]};
      ixalu_pkg::SZ_16: se64 = {{(W-16){d[15]}}, d[15:0]};
      default:          se64 = {{(W-32){d[31]}}, d[31:0]};
    endcase
    case (size_q)
      ixalu_pkg::SZ_8:  psx = {{(W-8){prod[7]}}, prod[7:0]};
      ixalu_pkg::SZ_16: psx = {{(W-16){prod[15]}}, prod[15:0]};
      default:          psx = {{(W-32){prod[31]}}, prod[31:0]};
    endcase
  end
  assign shl64 = x64 << cnt;
  assign shr64 = x64 >> cnt;
  assign sar64 = se64 >> cnt;

  always_comb begin
    sres = '0;
    scf  = 1'b0;
    case (kind_q)
      ixalu_pkg::K_SHR: begin
        sres = shr64[H-1:0] & m;
        scf  = x64[cm1];
      end
      ixalu_pkg::K_SAR: begin
        sres = sar64[H-1:0] & m;
        scf  = se64[cm1];
      end
      default: begin
        sres = shl64[H-1:0] & m;
        case (size_q)
          ixalu_pkg::SZ_8:  scf = shl64[8];
          ixalu_pkg::SZ_16: scf = shl64[16];
          default:          scf = shl64[32];
        endcase
      end
    endcase
  end

  function automatic logic even_par(input logic [7:0] b);
    even_par = ~(^b);
  endfunction

  always_comb begin
    val_n  = '0;
    cf_n   = cf;
    pf_n   = pf;
    zf_n   = zf;
    sf_n   = sf;
    of_n   = of;
    derr_n = 1'b0;
    case (kind_q)
      ixalu_pkg::K_ADD, ixalu_pkg::K_ADC: begin
        val_n = {{H{1'b0}}, sum33[H-1:0]};
        cf_n  = sum33[H];
        of_n  = ~(s[H-1] ^ d[H-1]) & (d[H-1] ^ sum33[H-1]);
        pf_n  = even_par(sum33[7:0]);
        zf_n  = (sum33[H-1:0] == '0);
        sf_n  = sum33[H-1];
      end
      ixalu_pkg::K_SUB, ixalu_pkg::K_SBB: begin
        val_n = {{H{1'b0}}, dif33[H-1:0]};
        cf_n  = dif33[H];
        of_n  = (s[H-1] ^ d[H-1]) & (d[H-1] ^ dif33[H-1]);
        pf_n  = even_par(dif33[7:0]);
        zf_n  = (dif33[H-1:0] == '0);
        sf_n  = dif33[H-1];
      end
      ixalu_pkg::K_MUL: begin
        val_n = prod;
        cf_n  = (prod > {{H{1'b0}}, m});
        of_n  = cf_n;
      end
      ixalu_pkg::K_IMUL: begin
        val_n = prod;
        cf_n  = (psx != prod);
        of_n  = cf_n;
      end
      ixalu_pkg::K_DIV, ixalu_pkg::K_IDIV: begin
        derr_n = (src_q == '0);
        val_n  = derr_n ? '0 : {{H{1'b0}}, div_q};
      end
      ixalu_pkg::K_MOD, ixalu_pkg::K_IMOD: begin
        derr_n = (src_q == '0);
        val_n  = derr_n ? '0 : {{H{1'b0}}, div_r};
      end
      ixalu_pkg::K_AND, ixalu_pkg::K_XOR, ixalu_pkg::K_OR: begin
        if (kind_q == ixalu_pkg::K_AND)      val_n = {{H{1'b0}}, d & s};
        else if (kind_q == ixalu_pkg::K_XOR) val_n = {{H{1'b0}}, d ^ s};
        else                                 val_n = {{H{1'b0}}, d | s};
        cf_n = 1'b0;
        of_n = 1'b0;
        pf_n = even_par(val_n[7:0]);
        zf_n = (val_n[H-1:0] == '0);
        sf_n = val_n[H-1];
      end
      ixalu_pkg::K_SHL, ixalu_pkg::K_SHR, ixalu_pkg::K_SAR, ixalu_pkg::K_SAL: begin
        if (cnt == '0) begin
          val_n = {{H{1'b0}}, d};
        end else begin
          val_n = {{H{1'b0}}, (d & ~m) | sres};
          cf_n  = scf;
          pf_n  = even_par(sres[7:0]);
          zf_n  = (sres == '0);
          case (size_q)
            ixalu_pkg::SZ_8:  sf_n = sres[7];
            ixalu_pkg::SZ_16: sf_n = sres[15];
            default:          sf_n = sres[31];
          endcase
        end
      end
      default: val_n = '0;
    endcase
  end

  // commit flags and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cf        <= 1'b0;
      pf        <= 1'b0;
      zf        <= 1'b0;
      sf        <= 1'b0;
      of        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (fin_go) begin
        cf           <= cf_n;
        pf           <= pf_n;
        zf           <= zf_n;
        sf           <= sf_n;
        of           <= of_n;
        out_valid    <= 1'b1;
        value        <= val_n;
        carry_out    <= cf_n;
        parity_out   <= pf_n;
        zero_out     <= zf_n;
        sign_out     <= sf_n;
        overflow_out <= of_n;
        divide_error <= derr_n;
      end
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == ixalu_pkg::ST_DIV) else $error("divider done outside divide");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> out_valid) else $error("finished transaction not presented");

  a_busy_only_div: assert property (@(posedge clk) disable iff (rst)
    div_sts.busy |-> state == ixalu_pkg::ST_DIV) else $error("divider busy outside divide");

endmodule

### rtl/core/ixalu_div.sv
// ----------------------------------------------------------------------------
// ixalu_div: iterative 64-bit divider
// Restoring radix-2 divide, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
module ixalu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  ixalu_pkg::div_ctrl_t          ctrl,
  input  logic [ixalu_pkg::WORD_W-1:0]  dividend,
  input  logic [ixalu_pkg::WORD_W-1:0]  divisor,
  output ixalu_pkg::div_sts_t           sts,
  output logic [ixalu_pkg::HALF_W-1:0]  quotient,
  output logic [ixalu_pkg::HALF_W-1:0]  remainder
);

  localparam int unsigned W = ixalu_pkg::WORD_W;

  logic         busy;
  logic         done;
  logic [5:0]   cnt;
  logic [W-1:0] qd;
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic         neg_q;
  logic         neg_r;

  logic         na;
  logic         nb;
  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] q_fix;
  logic [W-1:0] r_fix;

  assign na = ctrl.sgn & dividend[W-1];
  assign nb = ctrl.sgn & divisor[W-1];

  // shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, qd[W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        qd    <= na ? (W'(0) - dividend) : dividend;
        dvs   <= nb ? (W'(0) - divisor) : divisor;
        rem   <= '0;
        neg_q <= na ^ nb;
        neg_r <= na;
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          qd  <= {qd[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          qd  <= {qd[W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // apply result signs
  assign q_fix = neg_q ? (W'(0) - qd) : qd;
  assign r_fix = neg_r ? (W'(0) - rem) : rem;

  assign quotient  = q_fix[ixalu_pkg::HALF_W-1:0];
  assign remainder = r_fix[ixalu_pkg::HALF_W-1:0];
  assign sts.busy  = busy;
  assign sts.done  = done;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !busy) else $error("divider restarted while busy");

endmodule
